### rtl/lifo_pkg.sv
// shared types and constants for the bounded lifo stack with search
// no dependencies; imported by every module of the block
package lifo_pkg;

  // storage geometry
  localparam int DEPTH  = 64;
  localparam int WIDTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // request codes
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_FIND  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FIND
  } seq_state_t;

  // input transfer payload
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] value;
    logic [6:0]  index;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        found;
    logic [6:0]  entry_count;
    logic        is_empty;
    logic        is_full;
  } out_item_t;

  // sequencer to slot memory
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WIDTH-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

### rtl/lifo_mem.sv
// slot storage: one write port, one read port with registered read data
// depends on lifo_pkg
module lifo_mem (
  input  logic                     clk,
  input  lifo_pkg::mem_req_t       req,
  output logic [lifo_pkg::WIDTH-1:0] rd_data
);
  import lifo_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/lifo_seq.sv
// request sequencer: entry count, memory addressing and the find compare walk
// depends on lifo_pkg; drives lifo_mem through a mem_req_t
module lifo_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  lifo_pkg::in_item_t         item,
  output lifo_pkg::mem_req_t         mem_req,
  input  logic [lifo_pkg::WIDTH-1:0] rd_data,
  output logic                       busy,
  output logic                       res_valid,
  output lifo_pkg::out_item_t        res
);
  import lifo_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] walk_r, walk_nxt;
  logic [WIDTH-1:0] val_r, val_nxt;

  // state and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      walk_r  <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // next state, memory requests and result
  always_comb begin
    status_t          st;
    logic [31:0]      rd_ext;
    logic             hit;
    logic             emit;
    state_nxt = state_r;
    count_nxt = count_r;
    walk_nxt  = walk_r;
    val_nxt   = val_r;
    mem_req   = '0;
    st        = ST_OK;
    rd_ext    = '0;
    hit       = 1'b0;
    emit      = 1'b0;
    mem_req.wr_data = item.value[WIDTH-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt = item.value[WIDTH-1:0];
          case (item.action)
            OP_PUSH: begin
              emit = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                st = ST_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = count_r[ADDR_W-1:0];
                count_nxt       = count_r + 1'b1;
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                st   = ST_EMPTY;
                emit = 1'b1;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(count_r - 1'b1);
                count_nxt       = count_r - 1'b1;
                state_nxt       = S_READ;
              end
            end
            OP_FIND: begin
              if (count_r == '0) begin
                st   = ST_EMPTY;
                emit = 1'b1;
              end else begin
                // first entry is the bottom slot, walk upward
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                walk_nxt        = CNT_W'(1);
                state_nxt       = S_FIND;
              end
            end
            OP_READ: begin
              if (count_r == '0) begin
                st   = ST_EMPTY;
                emit = 1'b1;
              end else if (item.index == 7'd0 || 32'(item.index) > 32'(count_r)) begin
                st   = ST_RANGE;
                emit = 1'b1;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(count_r - CNT_W'(item.index));
                state_nxt       = S_READ;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              emit      = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        rd_ext[WIDTH-1:0] = rd_data;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FIND: begin
        // compare the entry fetched last cycle
        if (rd_data == val_r) begin
          hit       = 1'b1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else if (walk_r == count_r) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = walk_r[ADDR_W-1:0];
          walk_nxt        = walk_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_valid       = emit;
    res.status      = st;
    res.read_value  = rd_ext;
    res.found       = hit;
    res.entry_count = 7'(count_nxt);
    res.is_empty    = (count_nxt == '0);
    res.is_full     = (count_nxt == CNT_W'(DEPTH));
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/bounded_lifo_stack_with_search.sv
// results: push, clear, no-op and rejected requests pass straight to the output register;
//   pop and indexed read first pass the registered slot read; find walks one entry a cycle
// throughput: one request at a time, the next is taken once the result is registered
//   and the output register is free; the find walk through the slot memory sets the rate
// reset: entry count cleared, output empty; slot contents undefined until pushed
module bounded_lifo_stack_with_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lifo_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lifo_pkg::out_item_t out_data
);
  import lifo_pkg::*;

  mem_req_t         mem_req;
  logic [WIDTH-1:0] rd_data;
  logic             busy;
  logic             res_valid;
  out_item_t        res;
  logic             start;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  // take a request when idle and the result register can be freed
  assign in_stall = busy || (out_valid_r && out_stall);
  assign start    = in_valid && !in_stall;

  lifo_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (in_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  lifo_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
